// ===== design/pwbtf_pkg.sv =====
// ============================================================================
// pwbtf_pkg
// Shared types and constants of the page write buffer tag ring.
// ============================================================================
`default_nettype none

package pwbtf_pkg;

    localparam int DEF_SLOT_BITS = 11;
    localparam int DEF_MAX_PAGES = 32;

    localparam int SECTOR_W   = 48;
    localparam int COUNT_W    = 6;
    localparam int SLOT_W     = 11;
    localparam int SUMM_W     = 2;
    localparam int OP_W       = 2;

    localparam logic [SECTOR_W-1:0] SECTORS_PER_PAGE = 48'd8;

    // input tdata: sector, page_count, start_slot, zero pad
    localparam int S_TDATA_W = 72;
    // output tdata: status, hit, slot, read_summary, free_slots, tail_slot, zero pad
    localparam int M_TDATA_W = 40;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE    = 2'd0,
        OP_READ     = 2'd1,
        OP_COMPLETE = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    localparam logic [SUMM_W-1:0] SUMM_ALL  = 2'd0;
    localparam logic [SUMM_W-1:0] SUMM_NONE = 2'd1;
    localparam logic [SUMM_W-1:0] SUMM_SOME = 2'd2;

endpackage

`default_nettype wire

// ===== design/page_write_buffer_tag_fifo_unit.sv =====
// ============================================================================
// page_write_buffer_tag_fifo_unit
// Tag and control store of a page write buffer, kept as a ring of slots.
// ============================================================================
// Every page of a read or write request is looked up by one sequential sweep
// of the tag memory, one slot per cycle through a single 48-bit comparator,
// stopping early at the first indexed match. A completion marks its slots done
// one by one, then pops done slots off the tail. After reset the block clears
// its valid and done flags in one pass over all 2^SLOT_BITS slots before it
// takes its first item. Only one item is worked on at a time; s_tready is high
// while the block is idle.
`default_nettype none

module page_write_buffer_tag_fifo_unit #(
    parameter int SLOT_BITS = pwbtf_pkg::DEF_SLOT_BITS,
    parameter int MAX_PAGES = pwbtf_pkg::DEF_MAX_PAGES
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // s_tdata: sector[47:0], page_count[53:48], start_slot[64:54], zero [71:65]
    input  wire logic [pwbtf_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: op[1:0]
    input  wire logic [pwbtf_pkg::OP_W-1:0]       s_tuser,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // m_tdata: status[0], hit[1], slot[12:2], read_summary[14:13],
    //          free_slots[25:15], tail_slot[36:26], zero [39:37]
    output logic [pwbtf_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                  m_tlast,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready
);
    import pwbtf_pkg::*;

    localparam int SLOTS = 1 << SLOT_BITS;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_SCAN, S_WTAG, S_REMIT,
        S_MARK, S_POPRD, S_POPCHK
    } state_t;

    // memories
    logic [SECTOR_W-1:0] sec_mem [SLOTS];
    logic                ind_mem [SLOTS];
    logic                done_mem [SLOTS];

    state_t               state_reg;
    logic [OP_W-1:0]      op_reg;
    logic [SECTOR_W-1:0]  sec_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   pages_reg;
    logic [SLOT_BITS-1:0] start_reg;
    logic [SLOT_BITS-1:0] head_reg;
    logic [SLOT_BITS-1:0] tail_reg;
    logic [SLOT_BITS:0]   scan_reg;
    logic                 pend_reg;
    logic [SLOT_BITS-1:0] rd_addr_reg;
    logic [SECTOR_W-1:0]  rd_sec_reg;
    logic                 rd_ind_reg;
    logic                 rd_done_reg;
    logic                 hit_reg;
    logic [SLOT_BITS-1:0] where_reg;
    logic                 found_reg;
    logic                 missed_reg;

    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tlast_reg;
    logic                 m_tvalid_reg;

    // memory ports
    logic                 sec_we;
    logic                 ind_we;
    logic                 ind_wd;
    logic [SLOT_BITS-1:0] ind_wa;
    logic                 done_we;
    logic                 done_wd;
    logic [SLOT_BITS-1:0] done_wa;
    logic [SLOT_BITS-1:0] rd_addr;
    logic                 issue;

    logic                 out_free;
    logic                 dec_emit;
    logic                 out_load;
    logic [SLOT_BITS-1:0] free_now;
    logic [SLOT_BITS-1:0] free_wr;
    logic [COUNT_W-1:0]   in_count;
    logic [COUNT_W-1:0]   n_pages;
    logic                 match;
    logic                 miss_end;
    logic [31:0]          free_now_w;
    logic [31:0]          free_wr_w;
    logic [31:0]          tail_w;
    logic [31:0]          head_w;
    logic [31:0]          where_w;
    logic [31:0]          start_w;
    logic [SUMM_W-1:0]    summ;

    assign out_free   = !m_tvalid_reg || m_tready;
    assign free_now   = tail_reg - head_reg - 1'b1;
    assign free_wr    = free_now - SLOT_BITS'(pages_reg);
    assign free_now_w = 32'(free_now);
    assign free_wr_w  = 32'(free_wr);
    assign tail_w     = 32'(tail_reg);
    assign head_w     = 32'(head_reg);
    assign where_w    = 32'(where_reg);
    assign start_w    = 32'(s_tdata[64:54]);
    assign in_count   = count_reg;
    assign n_pages    = (in_count > COUNT_W'(MAX_PAGES)) ? COUNT_W'(MAX_PAGES) : in_count;

    assign issue    = (state_reg == S_SCAN) && !scan_reg[SLOT_BITS];
    assign rd_addr  = (state_reg == S_POPRD) ? tail_reg : scan_reg[SLOT_BITS-1:0];
    assign match    = pend_reg && rd_ind_reg && (rd_sec_reg == sec_reg);
    assign miss_end = pend_reg && !match && (rd_addr_reg == {SLOT_BITS{1'b1}});

    assign summ = (found_reg && missed_reg) ? SUMM_SOME : (found_reg ? SUMM_ALL : SUMM_NONE);

    // a result item is loaded into the output register this cycle
    assign dec_emit = (op_reg == OP_WRITE) ? ((free_now_w <= 32'(n_pages)) || n_pages == '0) :
                      (op_reg == OP_READ)  ? (n_pages == '0) :
                      (op_reg != OP_COMPLETE);
    assign out_load = out_free && ((state_reg == S_DECODE && dec_emit) ||
                                   state_reg == S_WTAG || state_reg == S_REMIT ||
                                   (state_reg == S_POPRD && head_reg == tail_reg) ||
                                   (state_reg == S_POPCHK && !rd_done_reg));

    always_comb
    begin
        sec_we  = 1'b0;
        ind_we  = 1'b0;
        ind_wd  = 1'b0;
        ind_wa  = head_reg;
        done_we = 1'b0;
        done_wd = 1'b0;
        done_wa = head_reg;
        case (state_reg)
            S_CLEAR:
            begin
                ind_we  = 1'b1;
                ind_wa  = scan_reg[SLOT_BITS-1:0];
                done_we = 1'b1;
                done_wa = scan_reg[SLOT_BITS-1:0];
            end
            S_SCAN:
            begin
                // unindex the older copy of this sector (writes only)
                if (match && op_reg == OP_WRITE)
                begin
                    ind_we = 1'b1;
                    ind_wa = rd_addr_reg;
                end
            end
            S_WTAG:
            begin
                if (out_free)
                begin
                    sec_we  = 1'b1;
                    ind_we  = 1'b1;
                    ind_wd  = 1'b1;
                    done_we = 1'b1;
                end
            end
            S_MARK:
            begin
                if (count_reg != '0)
                begin
                    done_we = 1'b1;
                    done_wd = 1'b1;
                    done_wa = start_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (sec_we)
        begin
            sec_mem[head_reg] <= sec_reg;
        end
        if (ind_we)
        begin
            ind_mem[ind_wa] <= ind_wd;
        end
        if (done_we)
        begin
            done_mem[done_wa] <= done_wd;
        end
        rd_sec_reg  <= sec_mem[rd_addr];
        rd_ind_reg  <= ind_mem[rd_addr];
        rd_done_reg <= done_mem[rd_addr];
        rd_addr_reg <= rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            scan_reg     <= '0;
            pend_reg     <= 1'b0;
            head_reg     <= '0;
            tail_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            m_tlast_reg  <= 1'b0;
            m_tdata_reg  <= '0;
            op_reg       <= '0;
            sec_reg      <= '0;
            count_reg    <= '0;
            pages_reg    <= '0;
            start_reg    <= '0;
            hit_reg      <= 1'b0;
            where_reg    <= '0;
            found_reg    <= 1'b0;
            missed_reg   <= 1'b0;
        end
        else
        begin
            pend_reg <= issue;
            if (m_tvalid_reg && m_tready && !out_load)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    scan_reg <= scan_reg + 1'b1;
                    if (scan_reg[SLOT_BITS-1:0] == {SLOT_BITS{1'b1}})
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        op_reg    <= s_tuser;
                        sec_reg   <= s_tdata[47:0];
                        count_reg <= s_tdata[53:48];
                        start_reg <= start_w[SLOT_BITS-1:0];
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    scan_reg   <= '0;
                    pages_reg  <= n_pages;
                    found_reg  <= 1'b0;
                    missed_reg <= 1'b0;
                    if (out_free)
                    begin
                        case (op_reg)
                            OP_WRITE:
                            begin
                                if (free_now_w <= 32'(n_pages) || n_pages == '0)
                                begin
                                    m_tvalid_reg <= 1'b1;
                                    m_tlast_reg  <= 1'b1;
                                    m_tdata_reg  <= {3'b000, tail_w[10:0], free_now_w[10:0],
                                                     SUMM_ALL, head_w[10:0], 1'b0,
                                                     (free_now_w <= 32'(n_pages))};
                                    state_reg    <= S_IDLE;
                                end
                                else
                                begin
                                    state_reg <= S_SCAN;
                                end
                            end
                            OP_READ:
                            begin
                                if (n_pages == '0)
                                begin
                                    m_tvalid_reg <= 1'b1;
                                    m_tlast_reg  <= 1'b1;
                                    m_tdata_reg  <= {3'b000, tail_w[10:0], free_now_w[10:0],
                                                     SUMM_NONE, 11'd0, 1'b0, 1'b0};
                                    state_reg    <= S_IDLE;
                                end
                                else
                                begin
                                    state_reg <= S_SCAN;
                                end
                            end
                            OP_COMPLETE:
                            begin
                                state_reg <= S_MARK;
                            end
                            default:
                            begin
                                m_tvalid_reg <= 1'b1;
                                m_tlast_reg  <= 1'b1;
                                m_tdata_reg  <= {3'b000, tail_w[10:0], free_now_w[10:0],
                                                 SUMM_ALL, 11'd0, 1'b0, 1'b0};
                                state_reg    <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (issue)
                    begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                    if (match || miss_end)
                    begin
                        hit_reg   <= match;
                        where_reg <= match ? rd_addr_reg : '0;
                        if (match)
                        begin
                            found_reg <= 1'b1;
                        end
                        else
                        begin
                            missed_reg <= 1'b1;
                        end
                        state_reg <= (op_reg == OP_WRITE) ? S_WTAG : S_REMIT;
                    end
                end
                S_WTAG:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tlast_reg  <= (pages_reg == COUNT_W'(1));
                        m_tdata_reg  <= {3'b000, tail_w[10:0], free_wr_w[10:0],
                                         SUMM_ALL, head_w[10:0], 1'b0, 1'b0};
                        head_reg     <= head_reg + 1'b1;
                        sec_reg      <= sec_reg + SECTORS_PER_PAGE;
                        pages_reg    <= pages_reg - 1'b1;
                        scan_reg     <= '0;
                        state_reg    <= (pages_reg == COUNT_W'(1)) ? S_IDLE : S_SCAN;
                    end
                end
                S_REMIT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tlast_reg  <= (pages_reg == COUNT_W'(1));
                        m_tdata_reg  <= {3'b000, tail_w[10:0], free_now_w[10:0],
                                         (pages_reg == COUNT_W'(1)) ? summ : SUMM_ALL,
                                         where_w[10:0], hit_reg, 1'b0};
                        sec_reg      <= sec_reg + SECTORS_PER_PAGE;
                        pages_reg    <= pages_reg - 1'b1;
                        scan_reg     <= '0;
                        state_reg    <= (pages_reg == COUNT_W'(1)) ? S_IDLE : S_SCAN;
                    end
                end
                S_MARK:
                begin
                    if (count_reg != '0)
                    begin
                        start_reg <= start_reg + 1'b1;
                        count_reg <= count_reg - 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_POPRD;
                    end
                end
                S_POPRD:
                begin
                    if (head_reg == tail_reg)
                    begin
                        if (out_free)
                        begin
                            m_tvalid_reg <= 1'b1;
                            m_tlast_reg  <= 1'b1;
                            m_tdata_reg  <= {3'b000, tail_w[10:0], free_now_w[10:0],
                                             SUMM_ALL, 11'd0, 1'b0, 1'b0};
                            state_reg    <= S_IDLE;
                        end
                    end
                    else
                    begin
                        state_reg <= S_POPCHK;
                    end
                end
                S_POPCHK:
                begin
                    // pop while the tail slot is done, else report
                    if (rd_done_reg)
                    begin
                        tail_reg  <= tail_reg + 1'b1;
                        state_reg <= S_POPRD;
                    end
                    else if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tlast_reg  <= 1'b1;
                        m_tdata_reg  <= {3'b000, tail_w[10:0], free_now_w[10:0],
                                         SUMM_ALL, 11'd0, 1'b0, 1'b0};
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

// ===== design/pwbtf_checker.sv =====
// ============================================================================
// pwbtf_checker
// Port-level checks on the page write buffer tag ring.
// ============================================================================
`default_nettype none

module pwbtf_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             s_tready,
    input wire logic [pwbtf_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire logic                             m_tlast,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready
);
    import pwbtf_pkg::*;

    // hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // a rejected write gives a single result
    a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tlast && !m_tdata[1])
        else $error("rejected write not a single result");

    // summary only on the last result
    a_summ_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[14:13] == SUMM_ALL)
        else $error("summary before last result");

    // a hit never carries a none summary
    a_hit_summ: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1] |-> m_tdata[14:13] != SUMM_NONE && m_tdata[14:13] != 2'd3)
        else $error("hit with bad summary");

    // no item taken while a mid-item result is pending
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("ready inside an item");

endmodule

bind page_write_buffer_tag_fifo_unit pwbtf_checker u_pwbtf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the page write buffer tag ring: a scoreboard keeps
// its own copy of tags, index and done flags, predicts every result item and
// checks the output stream while both sides idle and stall at random.
// ============================================================================

module tb;
    import pwbtf_pkg::*;

    localparam int RING = 1 << DEF_SLOT_BITS;

    typedef struct packed {
        logic              status;
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic [SUMM_W-1:0] summary;
        logic [SLOT_W-1:0] free_slots;
        logic [SLOT_W-1:0] tail_slot;
        logic              last;
    } ring_result_t;

    class ring_scoreboard;
        logic [SECTOR_W-1:0] tag [RING];
        bit                  indexed [RING];
        bit                  done [RING];
        logic [SLOT_W-1:0]   head;
        logic [SLOT_W-1:0]   tail;
        ring_result_t        awaited [$];
        int                  mismatches;

        function new();
            head = '0;
            tail = '0;
            mismatches = 0;
            foreach (indexed[i])
            begin
                indexed[i] = 0;
                done[i] = 0;
                tag[i] = '0;
            end
        endfunction

        function logic [SLOT_W-1:0] room();
            return tail - head - 1'b1;
        endfunction

        // lowest indexed slot holding the sector wins
        function bit find_tag(logic [SECTOR_W-1:0] sec, output logic [SLOT_W-1:0] where);
            where = '0;
            for (int i = 0; i < RING; i++)
            begin
                if (indexed[i] && tag[i] == sec)
                begin
                    where = SLOT_W'(i);
                    return 1;
                end
            end
            return 0;
        endfunction

        function void note_item(op_t op, logic [SECTOR_W-1:0] sec,
                                logic [COUNT_W-1:0] cnt, logic [SLOT_W-1:0] start);
            ring_result_t r;
            ring_result_t items [$];
            int pages;
            logic [SLOT_W-1:0] where;
            bit found;
            bit missed;
            pages = (cnt > DEF_MAX_PAGES) ? DEF_MAX_PAGES : cnt;
            found = 0;
            missed = 0;
            r = '0;
            case (op)
                OP_WRITE:
                begin
                    if (room() <= pages || pages == 0)
                    begin
                        r.status = (room() <= pages);
                        r.slot = head;
                        items.push_back(r);
                    end
                    else
                    begin
                        for (int i = 0; i < pages; i++)
                        begin
                            if (find_tag(sec, where))
                                indexed[where] = 0;
                            done[head] = 0;
                            tag[head] = sec;
                            indexed[head] = 1;
                            r.slot = head;
                            items.push_back(r);
                            head = head + 1'b1;
                            sec = sec + SECTORS_PER_PAGE;
                        end
                    end
                end
                OP_READ:
                begin
                    if (pages == 0)
                    begin
                        r.summary = SUMM_NONE;
                        items.push_back(r);
                    end
                    else
                    begin
                        for (int i = 0; i < pages; i++)
                        begin
                            r = '0;
                            if (find_tag(sec, where))
                            begin
                                found = 1;
                                r.hit = 1;
                                r.slot = where;
                            end
                            else
                                missed = 1;
                            items.push_back(r);
                            sec = sec + SECTORS_PER_PAGE;
                        end
                        items[items.size()-1].summary =
                            (found && missed) ? SUMM_SOME : (found ? SUMM_ALL : SUMM_NONE);
                    end
                end
                OP_COMPLETE:
                begin
                    for (int i = 0; i < cnt; i++)
                    begin
                        done[start] = 1;
                        start = start + 1'b1;
                    end
                    while (head != tail && done[tail])
                        tail = tail + 1'b1;
                    items.push_back(r);
                end
                default:
                    items.push_back(r);
            endcase
            foreach (items[i])
            begin
                items[i].free_slots = room();
                items[i].tail_slot = tail;
                items[i].last = (i == items.size() - 1);
                awaited.push_back(items[i]);
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] d, logic l);
            ring_result_t got;
            ring_result_t want;
            got = {d[0], d[1], d[12:2], d[14:13], d[25:15], d[36:26], l};
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item %h last %b", d, l);
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status || got.hit !== want.hit ||
                got.slot !== want.slot || got.summary !== want.summary ||
                got.free_slots !== want.free_slots || got.tail_slot !== want.tail_slot ||
                got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch: expected st%b hit%b slot%0d sum%0d free%0d tail%0d last%b",
                             want.status, want.hit, want.slot, want.summary, want.free_slots,
                             want.tail_slot, want.last);
                    $display("          got      st%b hit%b slot%0d sum%0d free%0d tail%0d last%b",
                             got.status, got.hit, got.slot, got.summary, got.free_slots,
                             got.tail_slot, got.last);
                end
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [OP_W-1:0]       s_tuser;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  m_tvalid;
    logic                  m_tready;

    ring_scoreboard        ring_sb;
    bit                    hold_request;
    logic [SECTOR_W-1:0]   base_pool [8];

    page_write_buffer_tag_fifo_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #2_000_000_000;
        $display("tb NOT OK");
        $finish;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // note every accepted item and check every accepted result
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            ring_sb.note_item(op_t'(s_tuser), s_tdata[47:0], s_tdata[53:48], s_tdata[64:54]);
        if (rst_n && m_tvalid && m_tready)
            ring_sb.check_result(m_tdata, m_tlast);
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_tready <= 1'b0;
                hold_request = 0;
                repeat (3000) @(posedge clk);
            end
            gap = pick_gap();
            if (gap == 0)
                m_tready <= 1'b1;
            else
            begin
                m_tready <= 1'b0;
                repeat (gap - 1) @(posedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_item(op_t op, logic [SECTOR_W-1:0] sec, logic [COUNT_W-1:0] cnt,
                             logic [SLOT_W-1:0] start);
        int gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {7'd0, start, cnt, sec};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        // let the item accepted at this edge reach the scoreboard
        @(posedge clk);
        while (ring_sb.awaited.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_random();
        int roll;
        int cnt;
        logic [SECTOR_W-1:0] sec;
        logic [SLOT_W-1:0] start;
        logic [SLOT_W-1:0] span;
        roll = $urandom_range(0, 99);
        if (roll < 85)
            cnt = $urandom_range(1, 2);
        else if (roll < 96)
            cnt = $urandom_range(0, 8);
        else
            cnt = $urandom_range(32, 63);
        if ($urandom_range(0, 9) < 7)
            sec = base_pool[$urandom_range(0, 7)] + SECTORS_PER_PAGE * $urandom_range(0, 3);
        else
            sec = SECTOR_W'({$urandom, $urandom});
        roll = $urandom_range(0, 99);
        if (roll < 38)
        begin
            if ($urandom_range(0, 3) == 0)
                base_pool[$urandom_range(0, 7)] = sec;
            send_item(OP_WRITE, sec, COUNT_W'(cnt), SLOT_W'($urandom));
        end
        else if (roll < 72)
            send_item(OP_READ, sec, COUNT_W'(cnt), SLOT_W'($urandom));
        else if (roll < 95)
        begin
            // mostly complete slots near the tail so the ring keeps moving
            span = ring_sb.head - ring_sb.tail;
            start = ring_sb.tail + ((span == 0) ? SLOT_W'(0) :
                                    SLOT_W'($urandom_range(0, span - 1)));
            if ($urandom_range(0, 4) == 0)
                start = SLOT_W'($urandom);
            send_item(OP_COMPLETE, sec, COUNT_W'($urandom_range(0, 6)), start);
        end
        else
            send_item(OP_NONE, sec, COUNT_W'(cnt), SLOT_W'($urandom));
    endtask

    initial
    begin
        ring_sb = new();
        hold_request = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_WRITE;
        foreach (base_pool[i])
            base_pool[i] = SECTOR_W'({$urandom, $urandom}) & 48'hFFFF_FFFF_FFF8;
        base_pool[0] = 48'hFFFF_FFFF_FFF8;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every op, zero and oversized counts, wrap of sector
        send_item(OP_WRITE, 48'd0, 6'd1, 11'd0);
        send_item(OP_WRITE, 48'hFFFF_FFFF_FFF8, 6'd3, 11'h7FF);
        send_item(OP_READ, 48'hFFFF_FFFF_FFF8, 6'd3, 11'd0);
        send_item(OP_READ, 48'hFFFF_FFFF_FFF0, 6'd3, 11'd0);
        send_item(OP_READ, 48'h1234_5678_9AB0, 6'd2, 11'd0);
        send_item(OP_READ, 48'd0, 6'd0, 11'd0);
        send_item(OP_WRITE, 48'd5, 6'd0, 11'd0);
        send_item(OP_WRITE, 48'd0, 6'd2, 11'd0);
        send_item(OP_READ, 48'd0, 6'd2, 11'd0);
        send_item(OP_COMPLETE, 48'd0, 6'd0, 11'd0);
        send_item(OP_COMPLETE, 48'd0, 6'd2, 11'd1);
        send_item(OP_COMPLETE, 48'd0, 6'd1, 11'd0);
        send_item(OP_NONE, 48'hFFFF_FFFF_FFFF, 6'h3F, 11'h7FF);
        send_item(OP_READ, 48'd0, 6'd1, 11'd0);
        send_item(OP_WRITE, 48'h5555_5555_5550, 6'd40, 11'd0);
        send_item(OP_READ, 48'h5555_5555_5550, 6'd63, 11'd0);
        send_item(OP_COMPLETE, 48'd0, 6'd63, ring_sb.tail);
        drain();

        // fill the ring by rewriting one window, then hit the room check
        while (ring_sb.room() > 32)
        begin
            send_item(OP_WRITE, 48'hA000, 6'd32, 11'd0);
            drain();
        end
        send_item(OP_WRITE, 48'hA000, COUNT_W'(ring_sb.room()), 11'd0);
        drain();
        if (ring_sb.room() > 1)
            send_item(OP_WRITE, 48'hA000, COUNT_W'(ring_sb.room() - 1'b1), 11'd0);
        drain();
        send_item(OP_WRITE, 48'hB000, 6'd1, 11'd0);
        send_item(OP_WRITE, 48'hB000, 6'd0, 11'd0);
        send_item(OP_READ, 48'hA000, 6'd32, 11'd0);
        drain();
        while (ring_sb.head != ring_sb.tail)
        begin
            send_item(OP_COMPLETE, 48'd0, 6'd63, ring_sb.tail);
            drain();
        end
        // popped slots stay readable until reused
        send_item(OP_READ, 48'hA000, 6'd4, 11'd0);

        for (int n = 0; n < 160; n++)
        begin
            if (n == 60)
                hold_request = 1;
            if (n == 150)
                drain();
            send_random();
        end
        drain();
        repeat (200) @(posedge clk);
        if (ring_sb.mismatches == 0 && ring_sb.awaited.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
